FILE: design/lcnc_pkg.sv
// Shared types, constants and digit arithmetic for the card number classifier.
`default_nettype none

package lcnc_pkg;

    localparam int DIGIT_W = 4;
    localparam int SUM_W   = 4;
    localparam int LEAD_W  = 7;

    localparam int LEN_SHORT_VISA = 13;
    localparam int LEN_AMEX       = 15;
    localparam int LEN_LONG       = 16;

    localparam logic [LEAD_W-1:0] LEAD_VISA_LO = 7'd40;
    localparam logic [LEAD_W-1:0] LEAD_VISA_HI = 7'd49;
    localparam logic [LEAD_W-1:0] LEAD_MC_LO   = 7'd51;
    localparam logic [LEAD_W-1:0] LEAD_MC_HI   = 7'd55;

    localparam logic [DIGIT_W-1:0] RADIX = 4'd10;

    typedef enum logic [1:0] {
        CLASS_INVALID    = 2'd0,
        CLASS_AMEX       = 2'd1,
        CLASS_VISA       = 2'd2,
        CLASS_MASTERCARD = 2'd3
    } card_class_t;

    // Fold a raw 4-bit code into 0..9.
    function automatic logic [DIGIT_W-1:0] fold_digit(input logic [DIGIT_W-1:0] d);
        return (d >= RADIX) ? d - RADIX : d;
    endfunction

    // Doubled Luhn digit: 2d, minus nine when it carries.
    function automatic logic [SUM_W-1:0] dbl_digit(input logic [DIGIT_W-1:0] d);
        logic [DIGIT_W:0] t;
        t = {d, 1'b0};
        return (t >= 5'd10) ? SUM_W'(t - 5'd9) : SUM_W'(t);
    endfunction

    // Sum of two values below ten, kept modulo ten.
    function automatic logic [SUM_W-1:0] add_mod10(input logic [SUM_W-1:0] s,
                                                   input logic [SUM_W-1:0] c);
        logic [SUM_W:0] t;
        t = {1'b0, s} + {1'b0, c};
        return (t >= 5'd10) ? SUM_W'(t - 5'd10) : SUM_W'(t);
    endfunction

endpackage

`default_nettype wire

FILE: design/luhn_card_number_classifier_core.sv
// Top level of the Luhn card number classifier.
`default_nettype none

// Card number classifier. Feed the decimal digits of a card number one word
// per cycle, most significant first, and raise last with the final digit.
// Codes above nine count as the code minus ten; zeros ahead of the first
// nonzero digit are ignored. The block keeps two running Luhn sums modulo ten
// (one per parity of the doubled positions), a digit count that saturates at
// MAX_DIGITS + 1, and the first two digits. The word carrying last produces
// exactly one card_class word: 0 invalid, 1 amex, 2 visa, 3 mastercard
// (13 digits visa, 15 amex, 16 visa on a leading 4 or mastercard on 51..55,
// anything else or a failed checksum invalid); the running state then clears
// for the next number. Words without last produce no result. Throughput is
// one digit per cycle: the state update and classification sit between the
// accumulator registers and a single output register, and the result appears
// in the cycle after the last digit is accepted. A held result may leave in the
// same cycle that the next digit enters, so digit_ready stays high while
// class_ready is high; digit_ready drops for as long as a held result is
// stalled by class_ready, and no digit is taken in those cycles.
module luhn_card_number_classifier_core import lcnc_pkg::*; #(
    parameter int MAX_DIGITS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               digit_valid,
    output logic                    digit_ready,
    input  wire logic [DIGIT_W-1:0] digit,
    input  wire logic               last,
    output logic                    class_valid,
    input  wire logic               class_ready,
    output logic [1:0]              card_class
);

    localparam int CNT_MAX = MAX_DIGITS + 1;
    localparam int CNT_W   = $clog2(CNT_MAX + 1);

    // Accumulator state
    logic [SUM_W-1:0]  sum_even_reg, sum_even_next;
    logic [SUM_W-1:0]  sum_odd_reg,  sum_odd_next;
    logic [CNT_W-1:0]  count_reg,    count_next;
    logic [LEAD_W-1:0] lead_reg,     lead_next;

    // Output register
    logic              class_valid_reg, class_valid_next;
    card_class_t       card_class_reg,  card_class_next;

    logic [DIGIT_W-1:0] d;
    logic [SUM_W-1:0]   d_dbl;
    logic               take;
    logic               skip;
    logic [SUM_W-1:0]   upd_even;
    logic [SUM_W-1:0]   upd_odd;
    logic [CNT_W-1:0]   upd_count;
    logic [LEAD_W-1:0]  upd_lead;
    card_class_t        decided;

    // Stall input only when a result is held and not taken.
    assign digit_ready = !class_valid_reg || class_ready;
    assign take        = digit_valid && digit_ready;

    assign d     = fold_digit(digit);
    assign d_dbl = dbl_digit(d);
    // Drop leading zeros: they leave every piece of state alone.
    assign skip  = (count_reg == '0) && (d == '0);

    always_comb
    begin
        upd_even  = sum_even_reg;
        upd_odd   = sum_odd_reg;
        upd_count = count_reg;
        upd_lead  = lead_reg;
        if (!skip)
        begin
            // Even count means this digit sits at an even position.
            if (!count_reg[0])
            begin
                upd_even = add_mod10(sum_even_reg, d_dbl);
                upd_odd  = add_mod10(sum_odd_reg, SUM_W'(d));
            end
            else
            begin
                upd_even = add_mod10(sum_even_reg, SUM_W'(d));
                upd_odd  = add_mod10(sum_odd_reg, d_dbl);
            end
            if (count_reg == CNT_W'(0))
                upd_lead = LEAD_W'(d);
            else if (count_reg == CNT_W'(1))
                upd_lead = LEAD_W'((lead_reg << 3) + (lead_reg << 1) + LEAD_W'(d));
            if (count_reg < CNT_W'(CNT_MAX))
                upd_count = count_reg + CNT_W'(1);
        end
    end

    lcnc_classify #(
        .CNT_W (CNT_W)
    ) u_classify (
        .count      (upd_count),
        .sum_even   (upd_even),
        .sum_odd    (upd_odd),
        .lead       (upd_lead),
        .card_class (decided)
    );

    always_comb
    begin
        sum_even_next    = sum_even_reg;
        sum_odd_next     = sum_odd_reg;
        count_next       = count_reg;
        lead_next        = lead_reg;
        class_valid_next = class_valid_reg && !class_ready;
        card_class_next  = card_class_reg;
        if (take)
        begin
            if (last)
            begin
                // Emit the class and clear for the next number.
                sum_even_next    = '0;
                sum_odd_next     = '0;
                count_next       = '0;
                lead_next        = '0;
                class_valid_next = 1'b1;
                card_class_next  = decided;
            end
            else
            begin
                sum_even_next = upd_even;
                sum_odd_next  = upd_odd;
                count_next    = upd_count;
                lead_next     = upd_lead;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_even_reg    <= '0;
            sum_odd_reg     <= '0;
            count_reg       <= '0;
            lead_reg        <= '0;
            class_valid_reg <= 1'b0;
        end
        else
        begin
            sum_even_reg    <= sum_even_next;
            sum_odd_reg     <= sum_odd_next;
            count_reg       <= count_next;
            lead_reg        <= lead_next;
            class_valid_reg <= class_valid_next;
        end
    end

    // Payload only; qualified by class_valid_reg.
    always_ff @(posedge clk)
    begin
        card_class_reg <= card_class_next;
    end

    assign class_valid = class_valid_reg;
    assign card_class  = card_class_reg;

    // A last digit always leaves a result and a cleared count behind.
    a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
        take && last |=> class_valid_reg && count_reg == '0)
        else $error("last digit did not produce a result or clear state");

    // The count never climbs past its saturation point.
    a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CNT_MAX))
        else $error("digit count beyond saturation");

    // Input stalls only behind a held result.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !digit_ready |-> class_valid_reg && !class_ready)
        else $error("input stalled without a pending result");

endmodule

`default_nettype wire

FILE: design/lcnc_classify.sv
// Length, Luhn and prefix decision for one complete card number.
`default_nettype none

module lcnc_classify import lcnc_pkg::*; #(
    parameter int CNT_W = 5
) (
    input  wire logic [CNT_W-1:0]  count,
    input  wire logic [SUM_W-1:0]  sum_even,
    input  wire logic [SUM_W-1:0]  sum_odd,
    input  wire logic [LEAD_W-1:0] lead,
    output card_class_t            card_class
);

    logic len_short;
    logic len_amex;
    logic len_long;
    logic luhn_ok;

    assign len_short = (count == CNT_W'(LEN_SHORT_VISA));
    assign len_amex  = (count == CNT_W'(LEN_AMEX));
    assign len_long  = (count == CNT_W'(LEN_LONG));

    // Doubled positions share the parity of the length.
    assign luhn_ok = count[0] ? (sum_odd == '0) : (sum_even == '0);

    always_comb
    begin
        card_class = CLASS_INVALID;
        if (luhn_ok)
        begin
            if (len_short)
                card_class = CLASS_VISA;
            else if (len_amex)
                card_class = CLASS_AMEX;
            else if (len_long)
            begin
                if (lead >= LEAD_VISA_LO && lead <= LEAD_VISA_HI)
                    card_class = CLASS_VISA;
                else if (lead >= LEAD_MC_LO && lead <= LEAD_MC_HI)
                    card_class = CLASS_MASTERCARD;
            end
        end
    end

endmodule

`default_nettype wire
